### rtl/subleq_processor_step_assert.svh
// ---------------------------------------------------------------------------
// SUBLEQ step engine assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them away.
// ---------------------------------------------------------------------------
`ifndef SUBLEQ_PROCESSOR_STEP_ASSERT_SVH
`define SUBLEQ_PROCESSOR_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked at every rising clock edge outside reset
`define SPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("subleq_processor_step: assertion failed");
// Property checked at every rising clock edge, reset included
`define SPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("subleq_processor_step: assertion failed");
`else
`define SPS_ASSERT(lbl, clk, rst_n, prop)
`define SPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/subleq_pkg.sv
// ---------------------------------------------------------------------------
// SUBLEQ package
// Sizes, control word layout, microprogram ROM and address helpers.
// ---------------------------------------------------------------------------
package subleq_pkg;

  // Memory size in 64-bit words (power of two)
  localparam int unsigned MEM_WORDS  = 65536;
  localparam int unsigned IDX_W      = $clog2(MEM_WORDS);
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned ADDR_W     = 19;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STEP_BYTES = 24;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_STEP = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // Microprogram addresses
  typedef enum logic [3:0] {
    U_CLR    = 4'd0,
    U_IDLE   = 4'd1,
    U_LOAD   = 4'd2,
    U_RD     = 4'd3,
    U_RD_FIN = 4'd4,
    U_FA     = 4'd5,
    U_FB     = 4'd6,
    U_FC     = 4'd7,
    U_RA     = 4'd8,
    U_RB     = 4'd9,
    U_SUB    = 4'd10,
    U_NONE   = 4'd11
  } upc_e;

  typedef enum logic [1:0] {
    MEM_IDLE,
    MEM_RD,
    MEM_WR
  } mem_op_e;

  typedef enum logic [2:0] {
    ASEL_CLR,
    ASEL_IN,
    ASEL_PC0,
    ASEL_PC1,
    ASEL_PC2,
    ASEL_A,
    ASEL_B
  } asel_e;

  typedef enum logic [1:0] {
    WSEL_ZERO,
    WSEL_IN,
    WSEL_DIFF
  } wsel_e;

  // Register loaded from the RAM read port
  typedef enum logic [2:0] {
    LAT_NONE,
    LAT_A_PTR,
    LAT_B_PTR,
    LAT_C,
    LAT_A_VAL
  } lat_e;

  // Result produced by a finishing step
  typedef enum logic [2:0] {
    RES_NONE,
    RES_LOAD,
    RES_READ,
    RES_STEP,
    RES_NULL
  } res_e;

  // Sequencing: go, loop until clear done, dispatch on input, finish on free output
  typedef enum logic [1:0] {
    SEQ_GO,
    SEQ_LOOP,
    SEQ_DISPATCH,
    SEQ_FINISH
  } seq_e;

  typedef struct packed {
    mem_op_e mem_op;
    asel_e   asel;
    wsel_e   wsel;
    lat_e    lat;
    res_e    res;
    seq_e    seq;
    upc_e    nxt;
  } ctrl_t;

  // Conditions seen by the sequencer
  typedef struct packed {
    logic  in_valid;
    kind_e kind;
    logic  clr_last;
    logic  out_free;
  } stat_t;

  // Byte address to word index, wrapping modulo MEM_WORDS
  function automatic logic [IDX_W-1:0] word_idx(input logic [WORD_W-1:0] byte_addr);
    logic [WORD_W-1:0] w;
    w = byte_addr >> 3;
    return w[IDX_W-1:0];
  endfunction

  // Microprogram ROM
  function automatic ctrl_t ucode(input upc_e upc);
    ctrl_t w;
    w = '{mem_op: MEM_IDLE, asel: ASEL_IN, wsel: WSEL_ZERO, lat: LAT_NONE,
          res: RES_NONE, seq: SEQ_GO, nxt: U_IDLE};
    case (upc)
      U_CLR: begin
        w.mem_op = MEM_WR; w.asel = ASEL_CLR; w.seq = SEQ_LOOP;
      end
      U_IDLE: begin
        w.seq = SEQ_DISPATCH;
      end
      U_LOAD: begin
        w.mem_op = MEM_WR; w.wsel = WSEL_IN; w.res = RES_LOAD; w.seq = SEQ_FINISH;
      end
      U_RD: begin
        w.mem_op = MEM_RD; w.nxt = U_RD_FIN;
      end
      U_RD_FIN: begin
        w.res = RES_READ; w.seq = SEQ_FINISH;
      end
      U_FA: begin
        w.mem_op = MEM_RD; w.asel = ASEL_PC0; w.nxt = U_FB;
      end
      U_FB: begin
        w.mem_op = MEM_RD; w.asel = ASEL_PC1; w.lat = LAT_A_PTR; w.nxt = U_FC;
      end
      U_FC: begin
        w.mem_op = MEM_RD; w.asel = ASEL_PC2; w.lat = LAT_B_PTR; w.nxt = U_RA;
      end
      U_RA: begin
        w.mem_op = MEM_RD; w.asel = ASEL_A; w.lat = LAT_C; w.nxt = U_RB;
      end
      U_RB: begin
        w.mem_op = MEM_RD; w.asel = ASEL_B; w.lat = LAT_A_VAL; w.nxt = U_SUB;
      end
      U_SUB: begin
        w.mem_op = MEM_WR; w.asel = ASEL_B; w.wsel = WSEL_DIFF;
        w.res = RES_STEP; w.seq = SEQ_FINISH;
      end
      U_NONE: begin
        w.res = RES_NULL; w.seq = SEQ_FINISH;
      end
      default: begin
        w.seq = SEQ_GO;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/subleq_processor_step.sv
// ---------------------------------------------------------------------------
// SUBLEQ processor step engine: executes load, read and step items from the input channel.
// A new item is taken only when idle; the step is six single-port RAM accesses plus dispatch.
// After reset the RAM is swept to zero, all MEM_WORDS (65536) words, with in_ready_o low.
// ---------------------------------------------------------------------------
`include "subleq_processor_step_assert.svh"

module subleq_processor_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [subleq_pkg::KIND_W-1:0]     in_kind_i,
  input  logic [subleq_pkg::ADDR_W-1:0]     in_address_i,
  input  logic [subleq_pkg::WORD_W-1:0]     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [subleq_pkg::ADDR_W-1:0]     out_program_counter_o,
  output logic [subleq_pkg::WORD_W-1:0]     out_word_value_o,
  output logic                              out_branched_o
);

  import subleq_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  fire;
  logic  fin_fire;

  // Captured item and operand registers
  logic [ADDR_W-1:0] addr_q;
  logic [WORD_W-1:0] data_q;
  logic [IDX_W-1:0]  ptr_a_q;
  logic [IDX_W-1:0]  ptr_b_q;
  logic [ADDR_W-1:0] c_q;
  logic [WORD_W-1:0] aval_q;
  logic [ADDR_W-1:0] pc_q;
  logic [IDX_W-1:0]  clr_cnt_q;
  logic              clr_done_q;

  // Output register
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_pc_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_br_q;

  // RAM port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic [IDX_W-1:0]  base_idx;
  logic [WORD_W-1:0] diff;
  logic              took;
  logic [ADDR_W-1:0] pc_next;

  // Sequencer status
  assign stat.in_valid = in_valid_i;
  assign stat.kind     = kind_e'(in_kind_i);
  assign stat.clr_last = (clr_cnt_q == IDX_W'(MEM_WORDS - 1));
  assign stat.out_free = !out_valid_q || out_ready_i;

  subleq_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .fire_o (fire)
  );

  assign in_ready_o = (ctrl.seq == SEQ_DISPATCH);
  assign fin_fire   = fire && (ctrl.seq == SEQ_FINISH);

  // Address generation
  assign base_idx = word_idx({{(WORD_W-ADDR_W){1'b0}}, pc_q});

  always_comb begin
    case (ctrl.asel)
      ASEL_CLR: ram_addr = clr_cnt_q;
      ASEL_IN:  ram_addr = word_idx({{(WORD_W-ADDR_W){1'b0}}, addr_q});
      ASEL_PC0: ram_addr = base_idx;
      ASEL_PC1: ram_addr = base_idx + IDX_W'(1);
      ASEL_PC2: ram_addr = base_idx + IDX_W'(2);
      ASEL_A:   ram_addr = ptr_a_q;
      ASEL_B:   ram_addr = ptr_b_q;
      default:  ram_addr = clr_cnt_q;
    endcase
  end

  // Subtract and branch decision
  assign diff    = ram_rdata - aval_q;
  assign took    = (diff == '0) || diff[WORD_W-1];
  assign pc_next = took ? c_q : pc_q + ADDR_W'(STEP_BYTES);

  always_comb begin
    case (ctrl.wsel)
      WSEL_ZERO: ram_wdata = '0;
      WSEL_IN:   ram_wdata = data_q;
      WSEL_DIFF: ram_wdata = diff;
      default:   ram_wdata = '0;
    endcase
  end

  // Writes happen only when the step actually fires
  assign ram_we = fire && (ctrl.mem_op == MEM_WR);

  subleq_ram #(
    .Width (WORD_W),
    .Depth (MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Control state: pc, clear sweep, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      clr_cnt_q   <= '0;
      clr_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire && ctrl.asel == ASEL_CLR && ctrl.mem_op == MEM_WR) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
        if (stat.clr_last) begin
          clr_done_q <= 1'b1;
        end
      end
      if (fin_fire && ctrl.res == RES_STEP) begin
        pc_q <= pc_next;
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (fire && ctrl.seq == SEQ_DISPATCH) begin
      addr_q <= in_address_i;
      data_q <= in_data_i;
    end
    if (fire) begin
      case (ctrl.lat)
        LAT_A_PTR: ptr_a_q <= word_idx(ram_rdata);
        LAT_B_PTR: ptr_b_q <= word_idx(ram_rdata);
        LAT_C:     c_q     <= ram_rdata[ADDR_W-1:0];
        LAT_A_VAL: aval_q  <= ram_rdata;
        default: begin
        end
      endcase
    end
    if (fin_fire) begin
      case (ctrl.res)
        RES_LOAD: begin
          out_pc_q   <= pc_q;
          out_word_q <= data_q;
          out_br_q   <= 1'b0;
        end
        RES_READ: begin
          out_pc_q   <= pc_q;
          out_word_q <= ram_rdata;
          out_br_q   <= 1'b0;
        end
        RES_STEP: begin
          out_pc_q   <= pc_next;
          out_word_q <= diff;
          out_br_q   <= took;
        end
        default: begin
          out_pc_q   <= pc_q;
          out_word_q <= '0;
          out_br_q   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_program_counter_o = out_pc_q;
  assign out_word_value_o      = out_word_q;
  assign out_branched_o        = out_br_q;

  // Assertions
  `SPS_ASSERT_ALWAYS(a_no_accept_before_clear, clk_i, (in_ready_o |-> clr_done_q))
  `SPS_ASSERT(a_branch_nonpositive, clk_i, rst_ni, (out_valid_o && out_branched_o |-> (out_word_value_o == '0 || out_word_value_o[WORD_W-1])))
  `SPS_ASSERT(a_no_write_while_idle, clk_i, rst_ni, (ram_we |-> !in_ready_o))
  `SPS_ASSERT(a_finish_gives_result, clk_i, rst_ni, (fin_fire |=> out_valid_o))

endmodule

### rtl/subleq_ram.sv
// ---------------------------------------------------------------------------
// SUBLEQ generic RAM
// Single-port synchronous RAM, read-first, registered read data.
// ---------------------------------------------------------------------------
module subleq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One access per cycle; read returns the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/subleq_seq.sv
// ---------------------------------------------------------------------------
// SUBLEQ microcode sequencer
// Step counter over the microprogram ROM with conditional jumps.
// ---------------------------------------------------------------------------
module subleq_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  subleq_pkg::stat_t  stat_i,
  output subleq_pkg::ctrl_t  ctrl_o,
  output logic               fire_o
);

  import subleq_pkg::*;

  upc_e  upc_q, upc_d;
  ctrl_t ctrl;
  logic  fire;

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

  // Control word lookup and next step
  always_comb begin
    ctrl  = ucode(upc_q);
    fire  = 1'b0;
    upc_d = upc_q;
    case (ctrl.seq)
      SEQ_GO: begin
        fire  = 1'b1;
        upc_d = ctrl.nxt;
      end
      SEQ_LOOP: begin
        fire = 1'b1;
        if (stat_i.clr_last) begin
          upc_d = ctrl.nxt;
        end
      end
      SEQ_DISPATCH: begin
        fire = stat_i.in_valid;
        if (stat_i.in_valid) begin
          case (stat_i.kind)
            KIND_LOAD: upc_d = U_LOAD;
            KIND_STEP: upc_d = U_FA;
            KIND_READ: upc_d = U_RD;
            default:   upc_d = U_NONE;
          endcase
        end
      end
      SEQ_FINISH: begin
        fire = stat_i.out_free;
        if (stat_i.out_free) begin
          upc_d = U_IDLE;
        end
      end
      default: begin
        upc_d = U_IDLE;
      end
    endcase
  end

  assign ctrl_o = ctrl;
  assign fire_o = fire;

endmodule

### verif/subleq_checker.sv
// ---------------------------------------------------------------------------
// SUBLEQ step engine checker
// Watches both channels, predicts every result from its own copy of memory
// and program counter, and compares each output transfer field by field.
// ---------------------------------------------------------------------------
module subleq_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [subleq_pkg::KIND_W-1:0] in_kind_i,
  input  logic [subleq_pkg::ADDR_W-1:0] in_address_i,
  input  logic [subleq_pkg::WORD_W-1:0] in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [subleq_pkg::ADDR_W-1:0] out_program_counter_i,
  input  logic [subleq_pkg::WORD_W-1:0] out_word_value_i,
  input  logic                          out_branched_i,
  output int                            pending_o,
  output int                            fail_count_o
);

  import subleq_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic [WORD_W-1:0] value;
    logic              branched;
  } step_result_t;

  // Shadow machine state
  logic [WORD_W-1:0] word_mem [MEM_WORDS];
  logic [ADDR_W-1:0] pc_q;
  step_result_t      expected_results[$];

  // One line per mismatch, and count it
  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  // Apply one input item to the shadow state and return its result
  function automatic step_result_t execute_item(input kind_e kind,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [WORD_W-1:0] data);
    step_result_t      r;
    logic [IDX_W-1:0]  slot_a, slot_b, slot_c;
    logic [WORD_W-1:0] a_ptr, b_ptr, c_tgt, diff;
    r = '{pc: pc_q, value: '0, branched: 1'b0};
    case (kind)
      KIND_LOAD: begin
        word_mem[addr[IDX_W+2:3]] = data;
        r.value = data;
      end
      KIND_READ: begin
        r.value = word_mem[addr[IDX_W+2:3]];
      end
      KIND_STEP: begin
        // operand fetch wraps around the end of memory
        slot_a = pc_q[IDX_W+2:3];
        slot_b = slot_a + IDX_W'(1);
        slot_c = slot_a + IDX_W'(2);
        a_ptr  = word_mem[slot_a];
        b_ptr  = word_mem[slot_b];
        c_tgt  = word_mem[slot_c];
        diff   = word_mem[b_ptr[IDX_W+2:3]] - word_mem[a_ptr[IDX_W+2:3]];
        word_mem[b_ptr[IDX_W+2:3]] = diff;
        r.value = diff;
        if (diff == '0 || diff[WORD_W-1]) begin
          pc_q       = c_tgt[ADDR_W-1:0];
          r.branched = 1'b1;
        end else begin
          pc_q = pc_q + ADDR_W'(STEP_BYTES);
        end
        r.pc = pc_q;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Compare output transfers, then queue the prediction for an input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t got, want;
    if (!rst_ni) begin
      foreach (word_mem[i]) word_mem[i] = '0;
      pc_q = '0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{pc: out_program_counter_i, value: out_word_value_i,
                branched: out_branched_i};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", got.value, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.pc !== want.pc) begin
            report_mismatch("program_counter", WORD_W'(got.pc), WORD_W'(want.pc));
          end
          if (got.value !== want.value) report_mismatch("word_value", got.value, want.value);
          if (got.branched !== want.branched) begin
            report_mismatch("branched", WORD_W'(got.branched), WORD_W'(want.branched));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(execute_item(kind_e'(in_kind_i), in_address_i,
                                                in_data_i));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

### verif/tb.sv
// ---------------------------------------------------------------------------
// SUBLEQ step engine testbench
// Directed loads, reads and steps, then random short programs and noise,
// with bursty input, stalling output and long output hold-offs.
// ---------------------------------------------------------------------------
module tb;
  import subleq_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind;
  logic [ADDR_W-1:0] in_address;
  logic [WORD_W-1:0] in_data;
  logic              out_valid;
  logic              out_ready;
  logic [ADDR_W-1:0] out_pc;
  logic [WORD_W-1:0] out_value;
  logic              out_branched;
  int                pending;
  int                fail_count;

  int                burst_left = 0;
  int                items_sent = 0;
  logic [ADDR_W-1:0] last_pc = '0;

  always #5 clk = ~clk;

  subleq_processor_step DUT (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .in_kind_i             (in_kind),
    .in_address_i          (in_address),
    .in_data_i             (in_data),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .out_program_counter_o (out_pc),
    .out_word_value_o      (out_value),
    .out_branched_o        (out_branched)
  );

  subleq_checker u_checker (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_i            (in_ready),
    .in_kind_i             (in_kind),
    .in_address_i          (in_address),
    .in_data_i             (in_data),
    .out_valid_i           (out_valid),
    .out_ready_i           (out_ready),
    .out_program_counter_i (out_pc),
    .out_word_value_i      (out_value),
    .out_branched_i        (out_branched),
    .pending_o             (pending),
    .fail_count_o          (fail_count)
  );

  // Track the machine's pc as reported, used to place new programs
  always @(posedge clk) begin
    if (out_valid && out_ready) last_pc <= out_pc;
  end

  // Offer one item; bursts of transfers separated by idle gaps
  task automatic send_item(input kind_e kind, input logic [ADDR_W-1:0] addr,
                           input logic [WORD_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_address <= addr;
    in_data    <= data;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Let every outstanding result come back
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Pointer word selecting a memory slot, with random low and high bits
  function automatic logic [WORD_W-1:0] word_ptr(input logic [IDX_W-1:0] slot);
    logic [WORD_W-1:0] p;
    p = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) p[WORD_W-1:ADDR_W] = '0;
    p[IDX_W+2:3] = slot;
    return p;
  endfunction

  // Operand values biased toward small magnitudes so both branch ways occur
  function automatic logic [WORD_W-1:0] operand_value();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1:    v = WORD_W'($urandom_range(0, 20));
      2:       v = WORD_W'(0) - WORD_W'($urandom_range(1, 20));
      3:       v = ($urandom_range(0, 1) == 1) ? {1'b1, {(WORD_W-1){1'b0}}}
                                               : {1'b0, {(WORD_W-1){1'b1}}};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Small program at the current pc over a small data area, then run it
  task automatic run_program();
    logic [ADDR_W-1:0] start;
    logic [IDX_W-1:0]  data_slot;
    logic [WORD_W-1:0] tgt;
    int                n_inst, n_data, n_ops;
    wait_drained();
    start     = last_pc;
    n_inst    = $urandom_range(1, 6);
    n_data    = $urandom_range(1, 4);
    data_slot = IDX_W'($urandom);
    for (int k = 0; k < n_data; k++) begin
      send_item(KIND_LOAD, {data_slot + IDX_W'(k), 3'($urandom_range(0, 7))},
                operand_value());
    end
    for (int k = 0; k < n_inst; k++) begin
      send_item(KIND_LOAD, start + ADDR_W'(STEP_BYTES * k),
                word_ptr(data_slot + IDX_W'($urandom_range(0, n_data - 1))));
      send_item(KIND_LOAD, start + ADDR_W'(STEP_BYTES * k + 8),
                word_ptr(data_slot + IDX_W'($urandom_range(0, n_data - 1))));
      tgt = {$urandom, $urandom};
      if ($urandom_range(0, 9) != 0) begin
        tgt[ADDR_W-1:0] = start + ADDR_W'(STEP_BYTES * $urandom_range(0, n_inst - 1));
      end
      send_item(KIND_LOAD, start + ADDR_W'(STEP_BYTES * k + 16), tgt);
    end
    n_ops = $urandom_range(4, 20);
    repeat (n_ops) begin
      case ($urandom_range(0, 7))
        0: send_item(KIND_READ,
                     {data_slot + IDX_W'($urandom_range(0, n_data - 1)),
                      3'($urandom_range(0, 7))}, {$urandom, $urandom});
        1: send_item(KIND_LOAD,
                     {data_slot + IDX_W'($urandom_range(0, n_data - 1)),
                      3'($urandom_range(0, 7))}, operand_value());
        default: send_item(KIND_STEP, ADDR_W'($urandom), {$urandom, $urandom});
      endcase
    end
  endtask

  // Unstructured items of every kind
  task automatic send_noise();
    repeat ($urandom_range(3, 12)) begin
      send_item(kind_e'($urandom_range(0, 3)), ADDR_W'($urandom), {$urandom, $urandom});
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_kind    <= KIND_NONE;
    in_address <= '0;
    in_data    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // unused kind and read of cleared memory
    send_item(KIND_NONE, '1, '1);
    send_item(KIND_READ, '0, '0);
    // extremes: top word, all ones
    send_item(KIND_LOAD, '1, '1);
    send_item(KIND_READ, 19'h7FFF8, '0);
    // data words and a non-branching step with wide pointers
    send_item(KIND_LOAD, 19'h00100, 64'd5);
    send_item(KIND_LOAD, 19'h00108, 64'd3);
    send_item(KIND_LOAD, 19'h00000, 64'hDEAD_BEEF_FFF8_010F);
    send_item(KIND_LOAD, 19'h00008, 64'h0000_0000_0000_0100);
    send_item(KIND_LOAD, 19'h00010, '1);
    send_item(KIND_STEP, '0, '0);
    // zero difference branches; target truncated to the top word
    send_item(KIND_LOAD, 19'h00018, 64'h0000_0000_0000_0100);
    send_item(KIND_LOAD, 19'h00020, 64'h0000_0000_0000_0104);
    send_item(KIND_LOAD, 19'h00028, '1);
    send_item(KIND_STEP, '1, '1);
    // fetch wraps from the last word to the first; negative result branches
    send_item(KIND_LOAD, 19'h7FFF8, 64'h0000_0000_0000_0108);
    send_item(KIND_LOAD, 19'h00000, 64'h0000_0000_0000_0100);
    send_item(KIND_LOAD, 19'h00008, 64'h0000_0000_0000_0030);
    send_item(KIND_STEP, '0, '0);
    send_item(KIND_READ, 19'h00107, '0);
    // signed overflow: most negative minus one is positive, no branch
    send_item(KIND_LOAD, 19'h00108, 64'd1);
    send_item(KIND_LOAD, 19'h00100, 64'h8000_0000_0000_0000);
    send_item(KIND_LOAD, 19'h00030, 64'h0000_0000_0000_0108);
    send_item(KIND_LOAD, 19'h00038, 64'h0000_0000_0000_0100);
    send_item(KIND_LOAD, 19'h00040, '0);
    send_item(KIND_STEP, '0, '0);

    // random programs and noise
    while (items_sent < 850) begin
      if ($urandom_range(0, 9) < 7) run_program();
      else send_noise();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Output side: stall patterns, plus long hold-offs that back up the input
  initial begin
    int mode, mode_left, seen, hold_at, phase;
    mode_left = 0;
    seen      = 0;
    hold_at   = 150;
    phase     = 0;
    mode      = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) seen++;
      if (seen >= hold_at && in_valid) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_at += 350;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ((phase % 5) < 2);
        endcase
      end
    end
  end

  // Timeout
  initial begin
    #10000000;
    $display("tb failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/subleq_pkg.sv
rtl/subleq_ram.sv
rtl/subleq_seq.sv
rtl/subleq_processor_step.sv
verif/subleq_checker.sv
verif/tb.sv
